FILE: rtl/core/lts_pkg.sv
// Package: widths, constants, reset values and helpers of the Langevin step core.
package lts_pkg;

  localparam int DEF_FRACTION_BITS = 32;
  localparam int POS_W      = 48;
  localparam int NOISE_W    = 32;
  localparam int DAMP_W     = 41;
  localparam int GAIN_W     = 40;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 41;

  localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_PRE_DAMP  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POST_DAMP = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAVY_PRE_DAMP  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAVY_POST_DAMP = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_GAIN      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAVY_GAIN      = 4'd7;

  localparam logic [TICK_W-1:0] RST_ON_TICKS  = 16'd15000;
  localparam logic [TICK_W-1:0] RST_OFF_TICKS = 16'd1000;
  localparam logic [DAMP_W-1:0] RST_LIGHT_PRE_DAMP  = 41'd1098961871962;
  localparam logic [DAMP_W-1:0] RST_LIGHT_POST_DAMP = 41'd1098962146703;
  localparam logic [DAMP_W-1:0] RST_HEAVY_PRE_DAMP  = 41'd1099511517825;
  localparam logic [DAMP_W-1:0] RST_HEAVY_POST_DAMP = 41'd1099511517825;
  localparam logic [GAIN_W-1:0] RST_LIGHT_GAIN = 40'd24585827520;
  localparam logic [GAIN_W-1:0] RST_HEAVY_GAIN = 40'd4917166;

  localparam logic [63:0] KICK_LIGHT   = 64'd549755814;
  localparam logic [63:0] KICK_HEAVY   = 64'd109951;
  localparam logic [63:0] DT_Q40       = 64'd1099511628;
  localparam logic [63:0] SPRING_Q40   = 64'd4398046511;
  localparam logic [63:0] RAD_PER_STEP = 64'd6746518852;
  localparam logic [63:0] AMP_Q32      = 64'd269860754090;
  localparam logic [63:0] ONE62        = 64'h4000_0000_0000_0000;

  // ceil(2^(62+l)/d), exact floor quotient for dividends below 2^62 when d <= 2^l
  function automatic logic [63:0] recip_c(input int unsigned d, input int unsigned l);
    logic [127:0] num;
    num = (128'd1 << (62 + l)) + 128'(d) - 128'd1;
    return 64'(num / 128'(d));
  endfunction

  localparam logic [63:0] RCP_C0 = recip_c(2, 1);
  localparam logic [63:0] RCP_C1 = recip_c(12, 4);
  localparam logic [63:0] RCP_C2 = recip_c(30, 5);
  localparam logic [63:0] RCP_C3 = recip_c(56, 6);
  localparam logic [63:0] RCP_C4 = recip_c(90, 7);
  localparam logic [63:0] RCP_C5 = recip_c(132, 8);
  localparam logic [63:0] RCP_C6 = recip_c(182, 8);
  localparam logic [63:0] RCP_S0 = recip_c(6, 3);
  localparam logic [63:0] RCP_S1 = recip_c(20, 5);
  localparam logic [63:0] RCP_S2 = recip_c(42, 6);
  localparam logic [63:0] RCP_S3 = recip_c(72, 7);
  localparam logic [63:0] RCP_S4 = recip_c(110, 7);
  localparam logic [63:0] RCP_S5 = recip_c(156, 8);

  function automatic logic [63:0] rcp_of(input logic use_cos, input logic [2:0] idx);
    logic [63:0] m;
    if (use_cos) begin
      unique case (idx)
        3'd0: m = RCP_C0;
        3'd1: m = RCP_C1;
        3'd2: m = RCP_C2;
        3'd3: m = RCP_C3;
        3'd4: m = RCP_C4;
        3'd5: m = RCP_C5;
        default: m = RCP_C6;
      endcase
    end else begin
      unique case (idx)
        3'd0: m = RCP_S0;
        3'd1: m = RCP_S1;
        3'd2: m = RCP_S2;
        3'd3: m = RCP_S3;
        3'd4: m = RCP_S4;
        default: m = RCP_S5;
      endcase
    end
    return m;
  endfunction

  function automatic logic [6:0] rcp_sh_of(input logic use_cos, input logic [2:0] idx);
    logic [6:0] s;
    if (use_cos) begin
      unique case (idx)
        3'd0: s = 7'd63;
        3'd1: s = 7'd66;
        3'd2: s = 7'd67;
        3'd3: s = 7'd68;
        3'd4: s = 7'd69;
        default: s = 7'd70;
      endcase
    end else begin
      unique case (idx)
        3'd0: s = 7'd65;
        3'd1: s = 7'd67;
        3'd2: s = 7'd68;
        3'd3, 3'd4: s = 7'd69;
        default: s = 7'd70;
      endcase
    end
    return s;
  endfunction

  function automatic logic [POS_W-1:0] sat49(input logic [POS_W:0] v);
    logic [POS_W-1:0] r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/langevin_two_particle_step_core.sv
// Top level: two-particle damped Langevin step on one shared 32x32 multiplier.
// Each multiply pass runs issue, four partial products, round and write back in turn;
//   15 passes per step, plus 17 (sine) or 18 (cosine) with the periodic force on, each
//   series divide being one reciprocal pass.
// One item at a time: a new item is accepted no earlier than the cycle after the result loads.
// Reset: synchronous active-low rst_n restores configuration registers, control state and particle state.
module langevin_two_particle_step_core
  import lts_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // light_noise_first, heavy_noise_first, light_noise_second, heavy_noise_second
  input  logic [127:0]          in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // light_position, heavy_position
  output logic [95:0]           out_tdata,
  // potential_phase
  output logic [0:0]            out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [63:0] SPRING_SCALED =
    ((SPRING_Q40 << 24) + (64'd1 << (63 - FRACTION_BITS))) >> (64 - FRACTION_BITS);
  localparam logic [POS_W-1:0] LF_RST = SPRING_SCALED[POS_W-1:0];
  localparam logic [POS_W-1:0] HF_RST = POS_W'(~SPRING_SCALED + 64'd1);
  localparam logic [POS_W-1:0] HPOS_RST = POS_W'(~(64'd1 << FRACTION_BITS) + 64'd1);
  localparam logic [6:0] SH_Q40   = 7'd40;
  localparam logic [6:0] SH_Q62   = 7'd62;
  localparam logic [6:0] SH_V     = 7'd22;
  localparam logic [6:0] SH_NOISE = 7'(68 - FRACTION_BITS);
  localparam logic [6:0] SH_AMP   = 7'(72 - FRACTION_BITS);
  localparam logic [6:0] WAVE_SH  = 7'(64 - FRACTION_BITS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_MUL, ST_RND, ST_WB, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_L1, OP_L2, OP_L3, OP_H1, OP_H2, OP_H3, OP_D1, OP_D2, OP_F1,
    OP_W1, OP_W2, OP_W3, OP_WD, OP_W4, OP_W5, OP_W6,
    OP_L4, OP_L5, OP_L6, OP_H4, OP_H5, OP_H6
  } op_t;

  state_t state_r;
  op_t    op_r;

  logic [TICK_W-1:0] on_ticks_r, off_ticks_r, ticks_r;
  logic [DAMP_W-1:0] lpre_r, lpost_r, hpre_r, hpost_r;
  logic [GAIN_W-1:0] lgain_r, hgain_r;

  logic [POS_W-1:0] lpos_r, hpos_r, lvel_r, hvel_r, lfor_r, hfor_r;
  logic             phase_r;
  logic [NOISE_W-1:0] n0_r, n1_r, n2_r, n3_r;

  logic [63:0]  a_r, b_r, y_r, y2_r, t_r;
  logic [6:0]   sh_r;
  logic         neg_r, cos_r, qhi_r;
  logic [127:0] acc_r;
  logic [1:0]   mcnt_r;
  logic [2:0]   idx_r;
  logic [63:0]  dvd_r;

  logic              out_valid_r;
  logic [POS_W-1:0]  out_lpos_r, out_hpos_r;
  logic              out_phase_r;
  logic              out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_ticks_r  <= RST_ON_TICKS;
      off_ticks_r <= RST_OFF_TICKS;
      lpre_r      <= RST_LIGHT_PRE_DAMP;
      lpost_r     <= RST_LIGHT_POST_DAMP;
      hpre_r      <= RST_HEAVY_PRE_DAMP;
      hpost_r     <= RST_HEAVY_POST_DAMP;
      lgain_r     <= RST_LIGHT_GAIN;
      hgain_r     <= RST_HEAVY_GAIN;
    end else if (cfg_wr_en) begin
      priority case (cfg_index)
        CFG_ON_TICKS:        on_ticks_r  <= cfg_wdata[TICK_W-1:0];
        CFG_OFF_TICKS:       off_ticks_r <= cfg_wdata[TICK_W-1:0];
        CFG_LIGHT_PRE_DAMP:  lpre_r      <= cfg_wdata[DAMP_W-1:0];
        CFG_LIGHT_POST_DAMP: lpost_r     <= cfg_wdata[DAMP_W-1:0];
        CFG_HEAVY_PRE_DAMP:  hpre_r      <= cfg_wdata[DAMP_W-1:0];
        CFG_HEAVY_POST_DAMP: hpost_r     <= cfg_wdata[DAMP_W-1:0];
        CFG_LIGHT_GAIN:      lgain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_HEAVY_GAIN:      hgain_r     <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // wave phase from the light position
  logic [63:0] wave_w;
  logic [29:0] wave_f;
  logic        wave_big;
  logic [29:0] wave_fr;
  always_comb begin
    wave_w   = {{(64-POS_W){lpos_r[POS_W-1]}}, lpos_r} << WAVE_SH;
    wave_f   = wave_w[61:32];
    wave_big = wave_f[29];
    wave_fr  = wave_big ? 30'(31'h4000_0000 - {1'b0, wave_f}) : wave_f;
  end

  // operand select
  logic [63:0] s_sel, ua_sel, b_sel, s_mag;
  logic        usgn_sel;
  logic [6:0]  sh_sel;
  always_comb begin
    s_sel    = '0;
    ua_sel   = '0;
    b_sel    = '0;
    usgn_sel = 1'b0;
    sh_sel   = SH_Q40;
    unique case (op_r)
      OP_L1: begin s_sel = {{16{lvel_r[47]}}, lvel_r}; b_sel = 64'(lpre_r); end
      OP_L2, OP_L4: begin s_sel = {{16{lfor_r[47]}}, lfor_r}; b_sel = KICK_LIGHT; end
      OP_L3: begin
        s_sel = {{32{n0_r[31]}}, n0_r}; b_sel = 64'(lgain_r); sh_sel = SH_NOISE;
      end
      OP_L5: begin
        s_sel = {{32{n2_r[31]}}, n2_r}; b_sel = 64'(lgain_r); sh_sel = SH_NOISE;
      end
      OP_L6: begin s_sel = {{16{lvel_r[47]}}, lvel_r}; b_sel = 64'(lpost_r); end
      OP_H1: begin s_sel = {{16{hvel_r[47]}}, hvel_r}; b_sel = 64'(hpre_r); end
      OP_H2, OP_H4: begin s_sel = {{16{hfor_r[47]}}, hfor_r}; b_sel = KICK_HEAVY; end
      OP_H3: begin
        s_sel = {{32{n1_r[31]}}, n1_r}; b_sel = 64'(hgain_r); sh_sel = SH_NOISE;
      end
      OP_H5: begin
        s_sel = {{32{n3_r[31]}}, n3_r}; b_sel = 64'(hgain_r); sh_sel = SH_NOISE;
      end
      OP_H6: begin s_sel = {{16{hvel_r[47]}}, hvel_r}; b_sel = 64'(hpost_r); end
      OP_D1: begin s_sel = {{16{lvel_r[47]}}, lvel_r}; b_sel = DT_Q40; end
      OP_D2: begin s_sel = {{16{hvel_r[47]}}, hvel_r}; b_sel = DT_Q40; end
      OP_F1: begin
        s_sel = {{16{hpos_r[47]}}, hpos_r} - {{16{lpos_r[47]}}, lpos_r};
        b_sel = SPRING_Q40;
      end
      OP_W1: begin
        usgn_sel = 1'b1; ua_sel = 64'(wave_fr); b_sel = RAD_PER_STEP; sh_sel = '0;
      end
      OP_W2: begin usgn_sel = 1'b1; ua_sel = y_r; b_sel = y_r; sh_sel = SH_Q62; end
      OP_W3: begin usgn_sel = 1'b1; ua_sel = y2_r; b_sel = t_r; sh_sel = SH_Q62; end
      OP_WD: begin
        usgn_sel = 1'b1; ua_sel = dvd_r;
        b_sel = rcp_of(cos_r, idx_r); sh_sel = rcp_sh_of(cos_r, idx_r);
      end
      OP_W4: begin usgn_sel = 1'b1; ua_sel = y_r; b_sel = t_r; sh_sel = SH_Q62; end
      OP_W5: begin usgn_sel = 1'b1; ua_sel = t_r; b_sel = 64'd1; sh_sel = SH_V; end
      OP_W6: begin usgn_sel = 1'b1; ua_sel = t_r; b_sel = AMP_Q32; sh_sel = SH_AMP; end
      default: ;
    endcase
    s_mag = s_sel[63] ? (~s_sel + 64'd1) : s_sel;
  end

  // shared multiplier datapath
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [6:0]   pp_amt;
  logic [127:0] pp_sh, rnd, shifted;
  logic [63:0]  r64, lim, mag;
  logic         ov;
  logic [POS_W-1:0] sres;
  always_comb begin
    a_half  = mcnt_r[0] ? a_r[63:32] : a_r[31:0];
    b_half  = mcnt_r[1] ? b_r[63:32] : b_r[31:0];
    pp      = 64'(a_half) * 64'(b_half);
    pp_amt  = {(2'(mcnt_r[0]) + 2'(mcnt_r[1])), 5'd0};
    pp_sh   = 128'(pp) << pp_amt;
    rnd     = (sh_r == 7'd0 || op_r == OP_WD) ? '0 : (128'd1 << (sh_r - 7'd1));
    shifted = acc_r >> sh_r;
    r64     = shifted[63:0];
    ov      = |shifted[127:64];
    lim     = neg_r ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
    mag     = (ov || (r64 > lim)) ? lim : r64;
    sres    = neg_r ? POS_W'(~mag + 64'd1) : mag[POS_W-1:0];
  end

  logic [POS_W-1:0] sext_sres;
  logic [POS_W-1:0] wave_term;
  always_comb begin
    sext_sres = sres;
    wave_term = qhi_r ? POS_W'(~sres + POS_W'(1)) : sres;
  end

  logic [TICK_W-1:0] dur;
  assign dur = phase_r ? off_ticks_r : on_ticks_r;

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_L1;
      lpos_r      <= '0;
      hpos_r      <= HPOS_RST;
      lvel_r      <= '0;
      hvel_r      <= '0;
      lfor_r      <= LF_RST;
      hfor_r      <= HF_RST;
      phase_r     <= 1'b0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
      idx_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            n0_r <= in_tdata[31:0];
            n1_r <= in_tdata[63:32];
            n2_r <= in_tdata[95:64];
            n3_r <= in_tdata[127:96];
            if (ticks_r >= dur) begin
              phase_r <= ~phase_r;
              ticks_r <= '0;
            end
            op_r    <= OP_L1;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          a_r    <= usgn_sel ? ua_sel : s_mag;
          neg_r  <= !usgn_sel && s_sel[63];
          b_r    <= b_sel;
          sh_r   <= sh_sel;
          acc_r  <= '0;
          mcnt_r <= '0;
          if (op_r == OP_W1) begin
            cos_r <= wave_w[62] ^ wave_big;
            qhi_r <= wave_w[63];
          end
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          acc_r  <= acc_r + pp_sh;
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd3) state_r <= ST_RND;
        end
        ST_RND: begin
          acc_r   <= acc_r + rnd;
          state_r <= ST_WB;
        end
        ST_WB: begin
          state_r <= (op_r == OP_H6) ? ST_OUT : ST_ISSUE;
          unique case (op_r)
            OP_L1: begin lvel_r <= sres; op_r <= OP_L2; end
            OP_L2: begin
              lvel_r <= sat49({lvel_r[47], lvel_r} - {sres[47], sres}); op_r <= OP_L3;
            end
            OP_L3: begin
              lvel_r <= sat49({lvel_r[47], lvel_r} + {sres[47], sres}); op_r <= OP_H1;
            end
            OP_H1: begin hvel_r <= sres; op_r <= OP_H2; end
            OP_H2: begin
              hvel_r <= sat49({hvel_r[47], hvel_r} - {sres[47], sres}); op_r <= OP_H3;
            end
            OP_H3: begin
              hvel_r <= sat49({hvel_r[47], hvel_r} + {sres[47], sres}); op_r <= OP_D1;
            end
            OP_D1: begin
              lpos_r <= sat49({lpos_r[47], lpos_r} + {sres[47], sres}); op_r <= OP_D2;
            end
            OP_D2: begin
              hpos_r <= sat49({hpos_r[47], hpos_r} + {sres[47], sres}); op_r <= OP_F1;
            end
            OP_F1: begin
              hfor_r <= sres;
              lfor_r <= sat49(49'd0 - {sres[47], sres});
              op_r   <= phase_r ? OP_L4 : OP_W1;
            end
            OP_W1: begin y_r <= r64; op_r <= OP_W2; end
            OP_W2: begin
              y2_r  <= r64;
              t_r   <= ONE62;
              idx_r <= cos_r ? 3'd6 : 3'd5;
              op_r  <= OP_W3;
            end
            OP_W3: begin dvd_r <= r64; op_r <= OP_WD; end
            OP_WD: begin
              t_r <= ONE62 - r64;
              if (idx_r == 3'd0) begin
                op_r <= cos_r ? OP_W5 : OP_W4;
              end else begin
                idx_r <= idx_r - 3'd1;
                op_r  <= OP_W3;
              end
            end
            OP_W4: begin t_r <= r64; op_r <= OP_W5; end
            OP_W5: begin t_r <= r64; op_r <= OP_W6; end
            OP_W6: begin
              lfor_r <= sat49({lfor_r[47], lfor_r} + {wave_term[47], wave_term});
              op_r   <= OP_L4;
            end
            OP_L4: begin
              lvel_r <= sat49({lvel_r[47], lvel_r} - {sres[47], sres}); op_r <= OP_L5;
            end
            OP_L5: begin
              lvel_r <= sat49({lvel_r[47], lvel_r} + {sext_sres[47], sext_sres});
              op_r   <= OP_L6;
            end
            OP_L6: begin lvel_r <= sres; op_r <= OP_H4; end
            OP_H4: begin
              hvel_r <= sat49({hvel_r[47], hvel_r} - {sres[47], sres}); op_r <= OP_H5;
            end
            OP_H5: begin
              hvel_r <= sat49({hvel_r[47], hvel_r} + {sres[47], sres}); op_r <= OP_H6;
            end
            OP_H6: begin hvel_r <= sres; end
            default: ;
          endcase
        end
        ST_OUT: begin
          if (out_load) begin
            out_lpos_r  <= lpos_r;
            out_hpos_r  <= hpos_r;
            out_phase_r <= phase_r;
            if (ticks_r != {TICK_W{1'b1}}) ticks_r <= ticks_r + TICK_W'(1);
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_hpos_r, out_lpos_r};
  assign out_tuser  = out_phase_r;

endmodule
